### design/eafe_pkg.sv
// Package for the escaped API frame encoder.
// Holds opcodes, register indexes, framing constants and the job record.
// No dependencies.
package eafe_pkg;

  localparam int MAX_PAYLOAD = 63;

  localparam logic [7:0] DELIM     = 8'h7E;
  localparam logic [7:0] ESC       = 8'h7D;
  localparam logic [7:0] XON       = 8'h11;
  localparam logic [7:0] XOFF      = 8'h13;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] CKSUM_TOP = 8'hFF;
  localparam logic [7:0] HDR_LEN   = 8'd11;

  localparam int JOB_BYTES = 15;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_DATA    = 2'd1,
    OP_ADVANCE = 2'd2
  } opcode_e;

  localparam logic [1:0] CFG_FRAME_ID    = 2'd0;
  localparam logic [1:0] CFG_CMD_OPTIONS = 2'd1;
  localparam logic [1:0] CFG_DEST_ADDR   = 2'd2;

  // Bytes one input word produces, emitted in order from index 0.
  typedef struct packed {
    logic [3:0]                    n_bytes;
    logic                          has_cksum;
    logic [JOB_BYTES-1:0][7:0]     bytes;
  } job_t;

endpackage

### design/escaped_api_frame_encoder.sv
// Escaped API frame encoder, top level.
// Instantiates eafe_framer and eafe_serializer; depends on eafe_pkg.
//
// Input channel (in_valid_i / in_stall_o) takes one word per handshake: a
// start word opens a frame and yields 14 header bytes (15 with the checksum
// when the count is zero), a payload word yields its byte or a two-byte
// escape plus the checksum after the last one, an advance word bumps the
// sequence number and yields nothing. Output channel (out_valid_o /
// out_stall_i) carries one stream byte per word; run_last_o marks the last
// byte of an input word and frame_end_o the checksum byte.
// The first byte of a word passes through the job register, then the output register.
// Throughput: one output byte per cycle while out_stall_i is low, set by the single
// output register; a word is accepted once the previous word's last byte has moved
// into the output register, so the input waits while a word's bytes drain (1 to 3 for
// payload, 14 or 15 for a start); words with no bytes load nothing into the job register.
// A stalled output holds its byte and backs up the job register, which then
// stalls the input. Reset clears the configuration and frame registers to zero,
// sets the sequence number to one and empties both stages.
module escaped_api_frame_encoder import eafe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  payload_count_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o
);

  logic in_acc, load_ok, job_valid;
  job_t job;

  assign in_stall_o = !load_ok;
  assign in_acc     = in_valid_i && load_ok;

  eafe_framer u_framer (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .accept_i    (in_acc),
    .opcode_i,
    .payload_count_i,
    .payload_byte_i,
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  eafe_serializer u_ser (
    .clk_i,
    .rst_ni,
    .load_i      (in_acc && job_valid),
    .job_i       (job),
    .load_ok_o   (load_ok),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .run_last_o,
    .frame_end_o
  );

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o)
    else $error("checksum byte not marked as last of its word");

  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_START) |=> in_stall_o)
    else $error("input not stalled while header is being sent");

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("gap inside the bytes of one word");

endmodule

### design/eafe_framer.sv
// Framer: configuration registers, frame state and the byte list built per word.
// Depends on eafe_pkg.
module eafe_framer import eafe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  payload_count_i,
  input  logic [7:0]  payload_byte_i,
  output logic        job_valid_o,
  output job_t        job_o
);

  logic [7:0]  frame_id_q, cmd_options_q, addr_sum_q;
  logic [63:0] dest_address_q;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  sum_q, sum_d;
  logic [5:0]  left_q, left_d;
  logic        open_q, open_d;

  logic [7:0]  cfg_sum;
  logic [7:0]  p01, p23, p45, p67;
  logic [5:0]  cnt_sat;
  logic [15:0] frame_len;
  logic [7:0]  hdr_sum, pay_sum;
  logic        is_special;
  logic [7:0]  seq_inc;

  // Address byte sum kept beside the address so the header sum stays short.
  always_comb begin
    p01 = cfg_data_i[63:56] + cfg_data_i[55:48];
    p23 = cfg_data_i[47:40] + cfg_data_i[39:32];
    p45 = cfg_data_i[31:24] + cfg_data_i[23:16];
    p67 = cfg_data_i[15:8]  + cfg_data_i[7:0];
    cfg_sum = (p01 + p23) + (p45 + p67);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q     <= '0;
      cmd_options_q  <= '0;
      dest_address_q <= '0;
      addr_sum_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_ID:    frame_id_q <= cfg_data_i[7:0];
        CFG_CMD_OPTIONS: cmd_options_q <= cfg_data_i[7:0];
        CFG_DEST_ADDR: begin
          dest_address_q <= cfg_data_i;
          addr_sum_q     <= cfg_sum;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_sat = ({2'b00, payload_count_i} > 8'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD)
                                                            : payload_count_i;
    frame_len  = 16'(HDR_LEN) + {10'd0, cnt_sat};
    hdr_sum    = frame_id_q + seq_q + cmd_options_q + addr_sum_q;
    pay_sum    = sum_q + payload_byte_i;
    is_special = (payload_byte_i == DELIM) || (payload_byte_i == ESC) ||
                 (payload_byte_i == XON)   || (payload_byte_i == XOFF);
    seq_inc    = seq_q + 8'd1;

    seq_d       = seq_q;
    sum_d       = sum_q;
    left_d      = left_q;
    open_d      = open_q;
    job_valid_o = 1'b0;
    job_o       = '0;

    case (opcode_e'(opcode_i))
      OP_START: begin
        job_valid_o     = 1'b1;
        job_o.bytes[0]  = DELIM;
        job_o.bytes[1]  = frame_len[15:8];
        job_o.bytes[2]  = frame_len[7:0];
        job_o.bytes[3]  = frame_id_q;
        job_o.bytes[4]  = seq_q;
        job_o.bytes[5]  = cmd_options_q;
        for (int i = 0; i < 8; i++) begin
          job_o.bytes[6+i] = dest_address_q[63-8*i -: 8];
        end
        job_o.bytes[14] = ~hdr_sum;
        if (cnt_sat == 6'd0) begin
          job_o.n_bytes   = 4'd15;
          job_o.has_cksum = 1'b1;
        end else begin
          job_o.n_bytes   = 4'd14;
        end
        sum_d  = hdr_sum;
        left_d = cnt_sat;
        open_d = (cnt_sat != 6'd0);
      end
      OP_DATA: begin
        if (open_q && (left_q != 6'd0)) begin
          job_valid_o = 1'b1;
          if (is_special) begin
            job_o.bytes[0] = ESC;
            job_o.bytes[1] = payload_byte_i ^ ESC_XOR;
            job_o.bytes[2] = CKSUM_TOP - pay_sum;
            job_o.n_bytes  = 4'd2;
          end else begin
            job_o.bytes[0] = payload_byte_i;
            job_o.bytes[1] = CKSUM_TOP - pay_sum;
            job_o.n_bytes  = 4'd1;
          end
          if (left_q == 6'd1) begin
            job_o.n_bytes   = job_o.n_bytes + 4'd1;
            job_o.has_cksum = 1'b1;
            open_d          = 1'b0;
          end
          sum_d  = pay_sum;
          left_d = left_q - 6'd1;
        end
      end
      OP_ADVANCE: begin
        seq_d = (seq_inc == 8'd0) ? 8'd1 : seq_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= 8'd1;
      sum_q  <= '0;
      left_q <= '0;
      open_q <= 1'b0;
    end else if (accept_i) begin
      seq_q  <= seq_d;
      sum_q  <= sum_d;
      left_q <= left_d;
      open_q <= open_d;
    end
  end

endmodule

### design/eafe_serializer.sv
// Serializer: job register and output register, one byte per cycle unless the output stalls.
// Depends on eafe_pkg.
module eafe_serializer import eafe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  job_t       job_i,
  output logic       load_ok_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  job_t       job_q;
  logic       job_valid_q;
  logic [3:0] idx_q;
  logic       out_valid_q, run_last_q, frame_end_q;
  logic [7:0] out_byte_q;

  logic out_free, emit, last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = job_valid_q && out_free;
  assign last      = (idx_q == job_q.n_bytes - 4'd1);
  assign load_ok_o = !job_valid_q || (emit && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load_i) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (emit) begin
        if (last) begin
          job_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= job_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= job_q.bytes[idx_q];
      run_last_q  <= last;
      frame_end_q <= last && job_q.has_cksum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

### tb/sv/tb_escaped_api_frame_encoder.sv
// Self-checking testbench for the escaped API frame encoder.
// Drives framing words through a directed table and then random phases, and
// scores every output byte against typed-in streams or a built-in frame model. Depends on eafe_pkg.
`timescale 1ns / 1ps

module tb_escaped_api_frame_encoder;
  import eafe_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int DIR_ROWS            = 25;
  localparam int RAND_WORDS          = 455;
  localparam int PHASE_EVENTS        = 8;
  localparam int HOLD_CYCLES         = 300;
  localparam int SETTLE_CYCLES       = 4;
  localparam int DRAIN_CYCLES        = 16;
  localparam int TIMEOUT_NS          = 800_000;
  localparam logic [119:0] NO_BYTES  = '0;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } stream_byte_t;

  // One directed word; when typed is set, the listed bytes are the expected stream.
  typedef struct packed {
    logic [1:0]       op;
    logic [5:0]       cnt;
    logic [7:0]       pb;
    logic             typed;
    logic [3:0]       n_bytes;
    logic             has_cksum;
    logic [0:14][7:0] bytes;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [63:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode     = '0;
  logic [5:0]  pay_count  = '0;
  logic [7:0]  pay_byte   = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_end;

  // model state and register mirror
  logic [7:0]  seq_num    = 8'd1;
  logic [7:0]  ck_sum     = '0;
  int          bytes_due  = 0;
  logic        frame_busy = 1'b0;
  logic [7:0]  fid_reg    = '0;
  logic [7:0]  opt_reg    = '0;
  logic [63:0] addr_reg   = '0;

  stream_byte_t stream_q[$];
  stream_byte_t word_bytes[$];
  stream_byte_t exp_b;
  dir_row_t     dir_tbl [DIR_ROWS];

  int   n_err       = 0;
  int   n_rand      = 0;
  int   burst_left  = 0;
  int   stall_mode  = 0;
  bit   gaps_on     = 1'b0;
  bit   hold_req    = 1'b0;

  always #1 clk = ~clk;

  escaped_api_frame_encoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .payload_count_i (pay_count),
    .payload_byte_i  (pay_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_o      (out_byte),
    .run_last_o      (run_last),
    .frame_end_o     (frame_end)
  );

  function automatic void put_byte(input logic [7:0] b, input logic fend);
    stream_byte_t sb;
    sb.data      = b;
    sb.run_last  = 1'b0;
    sb.frame_end = fend;
    word_bytes.push_back(sb);
  endfunction

  function automatic void close_frame();
    put_byte(CKSUM_TOP - ck_sum, 1'b1);
    frame_busy = 1'b0;
    bytes_due  = 0;
  endfunction

  // Stream bytes one accepted word produces; leaves them in word_bytes.
  function automatic void encode_word(input logic [1:0] op, input logic [5:0] cnt,
                                      input logic [7:0] pb);
    int         n;
    logic [15:0] len;
    logic [7:0] sum;
    logic [7:0] ab;
    word_bytes.delete();
    case (op)
      OP_START: begin
        n   = (cnt > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cnt);
        len = 16'(HDR_LEN) + 16'(n);
        put_byte(DELIM, 1'b0);
        put_byte(len[15:8], 1'b0);
        put_byte(len[7:0], 1'b0);
        put_byte(fid_reg, 1'b0);
        put_byte(seq_num, 1'b0);
        put_byte(opt_reg, 1'b0);
        sum = fid_reg + seq_num + opt_reg;
        for (int i = 7; i >= 0; i--) begin
          ab = addr_reg[i*8 +: 8];
          put_byte(ab, 1'b0);
          sum = sum + ab;
        end
        ck_sum     = sum;
        bytes_due  = n;
        frame_busy = 1'b1;
        if (n == 0) close_frame();
      end
      OP_DATA: begin
        if (frame_busy && bytes_due != 0) begin
          if (pb == DELIM || pb == ESC || pb == XON || pb == XOFF) begin
            put_byte(ESC, 1'b0);
            put_byte(pb ^ ESC_XOR, 1'b0);
          end else begin
            put_byte(pb, 1'b0);
          end
          ck_sum    = ck_sum + pb;
          bytes_due = bytes_due - 1;
          if (bytes_due == 0) close_frame();
        end
      end
      OP_ADVANCE: begin
        seq_num = seq_num + 8'd1;
        if (seq_num == 8'd0) seq_num = 8'd1;
      end
      default: ;
    endcase
    if (word_bytes.size() != 0) word_bytes[word_bytes.size()-1].run_last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return DELIM;
      1:       return ESC;
      2:       return XON;
      3:       return XOFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one word; returns at the rising edge where it is taken.
  task automatic send_word(input logic [1:0] op, input logic [5:0] cnt,
                           input logic [7:0] pb);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    opcode    = op;
    pay_count = cnt;
    pay_byte  = pb;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drive_word(input logic [1:0] op, input logic [5:0] cnt,
                            input logic [7:0] pb);
    send_word(op, cnt, pb);
    encode_word(op, cnt, pb);
    foreach (word_bytes[j]) stream_q.push_back(word_bytes[j]);
    n_rand++;
  endtask

  // Drop valid, let every expected byte out, then give the block time to go quiet.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_FRAME_ID:    fid_reg  = data[7:0];
      CFG_CMD_OPTIONS: opt_reg  = data[7:0];
      CFG_DEST_ADDR:   addr_reg = data;
      default: ;
    endcase
  endtask

  // Output scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (stream_q.size() == 0) begin
        $error("unexpected output word: out_byte %h run_last %b frame_end %b",
               out_byte, run_last, frame_end);
        n_err++;
      end else begin
        exp_b = stream_q.pop_front();
        if (out_byte !== exp_b.data) begin
          $error("out_byte: expected %h, got %h", exp_b.data, out_byte);
          n_err++;
        end
        if (run_last !== exp_b.run_last) begin
          $error("run_last: expected %b, got %b", exp_b.run_last, run_last);
          n_err++;
        end
        if (frame_end !== exp_b.frame_end) begin
          $error("frame_end: expected %b, got %b", exp_b.frame_end, frame_end);
          n_err++;
        end
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a per-phase stall pattern.
  initial begin : rx_pattern
    int run;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        run = 0;
      end else if (run > 0) begin
        run = run - 1;
      end else begin
        case (stall_mode)
          0: out_stall = 1'b0;
          1: begin
            out_stall = ($urandom_range(0, 2) == 0);
            run = $urandom_range(0, 3);
          end
          default: begin
            out_stall = ~out_stall;
            run = out_stall ? $urandom_range(0, 8) : $urandom_range(0, 20);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    dir_row_t     row;
    stream_byte_t sb;
    int           k, r, phase;
    logic [5:0]   cnt;
    logic [7:0]   fid, opt;
    logic [63:0]  addr, junk;

    // Rows 0-7 run on reset registers and have their streams typed in.
    dir_tbl[0]  = {OP_UNUSED,  6'h3F, 8'hFF, 1'b1, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[1]  = {OP_DATA,    6'h00, 8'h7E, 1'b1, 4'd0,  1'b0, NO_BYTES};  // stray
    dir_tbl[2]  = {OP_START,   6'd0,  8'hFF, 1'b1, 4'd15, 1'b1,
                   120'h7E000B_000100_0000000000000000_FE};                 // empty frame
    dir_tbl[3]  = {OP_DATA,    6'h3F, 8'h00, 1'b1, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[4]  = {OP_ADVANCE, 6'h15, 8'hA5, 1'b1, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[5]  = {OP_START,   6'd0,  8'h00, 1'b1, 4'd15, 1'b1,
                   120'h7E000B_000200_0000000000000000_FD};
    dir_tbl[6]  = {OP_START,   6'd1,  8'hAA, 1'b1, 4'd14, 1'b0,
                   120'h7E000C_000200_0000000000000000_00};
    dir_tbl[7]  = {OP_DATA,    6'h3F, 8'h7E, 1'b1, 4'd3,  1'b1, {24'h7D5E7F, 96'h0}};
    dir_tbl[8]  = {OP_START,   6'd63, 8'h55, 1'b0, 4'd0,  1'b0, NO_BYTES};  // max count
    dir_tbl[9]  = {OP_DATA,    6'h00, 8'h7D, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[10] = {OP_DATA,    6'h2A, 8'h11, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[11] = {OP_DATA,    6'h15, 8'h13, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[12] = {OP_DATA,    6'h3F, 8'h00, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[13] = {OP_DATA,    6'h00, 8'hFF, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[14] = {OP_ADVANCE, 6'h3F, 8'hFF, 1'b0, 4'd0,  1'b0, NO_BYTES};  // mid-frame
    dir_tbl[15] = {OP_UNUSED,  6'h00, 8'h00, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[16] = {OP_DATA,    6'h01, 8'h7E, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[17] = {OP_START,   6'd2,  8'h7E, 1'b0, 4'd0,  1'b0, NO_BYTES};  // abandons frame
    dir_tbl[18] = {OP_DATA,    6'h00, 8'h20, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[19] = {OP_DATA,    6'h00, 8'h5D, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[20] = {OP_START,   6'd3,  8'h00, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[21] = {OP_DATA,    6'h00, 8'h12, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[22] = {OP_DATA,    6'h00, 8'h7F, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[23] = {OP_DATA,    6'h00, 8'h10, 1'b0, 4'd0,  1'b0, NO_BYTES};
    dir_tbl[24] = {OP_DATA,    6'h00, 8'h13, 1'b0, 4'd0,  1'b0, NO_BYTES};  // stray again

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    stall_mode = 1;
    gaps_on    = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tbl[i];
      if (row.typed) begin
        send_word(row.op, row.cnt, row.pb);
        encode_word(row.op, row.cnt, row.pb);   // keeps model state in step
        for (k = 0; k < row.n_bytes; k++) begin
          sb.data      = row.bytes[k];
          sb.run_last  = (k == row.n_bytes - 1);
          sb.frame_end = row.has_cksum && (k == row.n_bytes - 1);
          stream_q.push_back(sb);
        end
      end else begin
        drive_word(row.op, row.cnt, row.pb);
      end
    end

    n_rand = 0;
    phase = 0;
    while (n_rand < RAND_WORDS) begin
      wait_idle();
      case (phase % 4)
        0: begin fid = 8'hFF; opt = 8'hFF; addr = '1; end
        1: begin fid = 8'h00; opt = 8'h00; addr = '0; end
        2: begin
          fid = rand_payload();
          opt = rand_payload();
          for (k = 0; k < 8; k++) addr[k*8 +: 8] = rand_payload();
        end
        default: begin
          fid  = 8'($urandom_range(0, 255));
          opt  = 8'($urandom_range(0, 255));
          addr = {$urandom, $urandom};
        end
      endcase
      junk = {$urandom, $urandom};
      cfg_write(CFG_FRAME_ID, {junk[63:8], fid});
      junk = {$urandom, $urandom};
      cfg_write(CFG_CMD_OPTIONS, {junk[63:8], opt});
      cfg_write(CFG_DEST_ADDR, addr);
      if (phase == 0) cfg_write(CFG_UNUSED, {$urandom, $urandom});

      stall_mode = phase % 3;
      gaps_on    = (phase % 3 != 0);

      // full-size frame against a long output hold-off: backs up into the input
      if (phase == 1) begin
        hold_req = 1'b1;
        drive_word(OP_START, 6'd63, 8'($urandom_range(0, 255)));
        for (k = 0; k < 63; k++) begin
          drive_word(OP_DATA, 6'($urandom_range(0, 63)), rand_payload());
        end
      end

      // enough advances to wrap the sequence number past zero
      if (phase == 3) begin
        repeat (256) begin
          drive_word(OP_ADVANCE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end
        drive_word(OP_START, 6'd0, 8'($urandom_range(0, 255)));
      end

      for (int e = 0; e < PHASE_EVENTS; e++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          cnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 6));
          drive_word(OP_START, cnt, 8'($urandom_range(0, 255)));
          for (k = 0; k < cnt; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
              drive_word(OP_ADVANCE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            end else if (r < 5) begin
              drive_word(OP_UNUSED, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            end else if (r >= 97) begin
              break;   // frame left open, next start abandons it
            end
            drive_word(OP_DATA, 6'($urandom_range(0, 63)), rand_payload());
          end
        end else if (r < 75) begin
          drive_word(OP_ADVANCE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end else if (r < 83) begin
          drive_word(OP_UNUSED, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end else if (r < 95) begin
          drive_word(OP_DATA, 6'($urandom_range(0, 63)), rand_payload());
        end else begin
          wait_idle();
        end
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("** escaped_api_frame_encoder: PASSED **");
    end else begin
      $display("** escaped_api_frame_encoder: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** escaped_api_frame_encoder: FAILED **");
    $finish;
  end

endmodule
